// ===== design/tpo_pkg.sv =====
package tpo_pkg;

  localparam int unsigned CoordBits = 12;
  // Edge vectors need one extra bit, cross products twice that plus one.
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned CrossBits = 2 * DiffBits + 1;
  localparam int unsigned NumVerts  = 3;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [CrossBits-1:0] cross_t;

  typedef struct packed {
    coord_t a_x0;
    coord_t a_y0;
    coord_t a_x1;
    coord_t a_y1;
    coord_t a_x2;
    coord_t a_y2;
    coord_t b_x0;
    coord_t b_y0;
    coord_t b_x1;
    coord_t b_y1;
    coord_t b_x2;
    coord_t b_y2;
  } tri_pair_t;

  typedef struct packed {
    logic overlap;
    logic edge_crossing;
    logic vertex_inside;
  } tpo_result_t;

  // Edge vectors and offsets for one edge pair or one containment test.
  typedef struct packed {
    diff_t rx;
    diff_t ry;
    diff_t sx;
    diff_t sy;
    diff_t wx;
    diff_t wy;
  } vec_set_t;

  // Three cross products: denominator and two numerators.
  typedef struct packed {
    cross_t d;
    cross_t n0;
    cross_t n1;
  } cross_set_t;

  // Difference of two coordinates, sign extended.
  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  // Cross product a x b.
  function automatic cross_t cross_v(diff_t ax, diff_t ay, diff_t bx, diff_t by);
    logic signed [2*DiffBits-1:0] p0;
    logic signed [2*DiffBits-1:0] p1;
    p0 = ax * by;
    p1 = ay * bx;
    return cross_t'(p0) - cross_t'(p1);
  endfunction

  // Exact test 0 <= n/d <= 1 for nonzero d.
  function automatic logic unit_ratio(cross_t n, cross_t d);
    if (d > 0) begin
      return (n >= 0) && (n <= d);
    end
    return (n <= 0) && (n >= d);
  endfunction

endpackage

// ===== design/tpo_vec.sv =====
// Stage 1: edge vectors for every pairing of an edge of A with an edge of B, and for both containment tests.
module tpo_vec (
  input  logic               clk_i,
  input  logic               en_i,
  input  tpo_pkg::tri_pair_t in_i,
  output tpo_pkg::vec_set_t  edge_o [9],
  output tpo_pkg::vec_set_t  cont_o [2]
);

  tpo_pkg::coord_t ax [3];
  tpo_pkg::coord_t ay [3];
  tpo_pkg::coord_t bx [3];
  tpo_pkg::coord_t by [3];
  tpo_pkg::vec_set_t edge_d [9];
  tpo_pkg::vec_set_t cont_d [2];
  tpo_pkg::vec_set_t edge_q [9];
  tpo_pkg::vec_set_t cont_q [2];

  assign ax[0] = in_i.a_x0;
  assign ay[0] = in_i.a_y0;
  assign ax[1] = in_i.a_x1;
  assign ay[1] = in_i.a_y1;
  assign ax[2] = in_i.a_x2;
  assign ay[2] = in_i.a_y2;
  assign bx[0] = in_i.b_x0;
  assign by[0] = in_i.b_y0;
  assign bx[1] = in_i.b_x1;
  assign by[1] = in_i.b_y1;
  assign bx[2] = in_i.b_x2;
  assign by[2] = in_i.b_y2;

  // One lane per edge pair: r = edge of A, s = edge of B, w = q1 - p1.
  for (genvar i = 0; i < 3; i++) begin : g_a
    for (genvar j = 0; j < 3; j++) begin : g_b
      always_comb begin
        edge_d[3*i+j].rx = tpo_pkg::sub_c(ax[(i+1)%3], ax[i]);
        edge_d[3*i+j].ry = tpo_pkg::sub_c(ay[(i+1)%3], ay[i]);
        edge_d[3*i+j].sx = tpo_pkg::sub_c(bx[(j+1)%3], bx[j]);
        edge_d[3*i+j].sy = tpo_pkg::sub_c(by[(j+1)%3], by[j]);
        edge_d[3*i+j].wx = tpo_pkg::sub_c(bx[j], ax[i]);
        edge_d[3*i+j].wy = tpo_pkg::sub_c(by[j], ay[i]);
      end
    end
  end

  // Containment: r = v0 = c-a, s = v1 = b-a, w = v2 = p-a.
  always_comb begin
    cont_d[0].rx = tpo_pkg::sub_c(bx[2], bx[0]);
    cont_d[0].ry = tpo_pkg::sub_c(by[2], by[0]);
    cont_d[0].sx = tpo_pkg::sub_c(bx[1], bx[0]);
    cont_d[0].sy = tpo_pkg::sub_c(by[1], by[0]);
    cont_d[0].wx = tpo_pkg::sub_c(ax[0], bx[0]);
    cont_d[0].wy = tpo_pkg::sub_c(ay[0], by[0]);
    cont_d[1].rx = tpo_pkg::sub_c(ax[2], ax[0]);
    cont_d[1].ry = tpo_pkg::sub_c(ay[2], ay[0]);
    cont_d[1].sx = tpo_pkg::sub_c(ax[1], ax[0]);
    cont_d[1].sy = tpo_pkg::sub_c(ay[1], ay[0]);
    cont_d[1].wx = tpo_pkg::sub_c(bx[0], ax[0]);
    cont_d[1].wy = tpo_pkg::sub_c(by[0], ay[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      edge_q <= edge_d;
      cont_q <= cont_d;
    end
  end

  assign edge_o = edge_q;
  assign cont_o = cont_q;

endmodule

// ===== design/tpo_cross.sv =====
// Stage 2: three cross products per lane, registered.
module tpo_cross (
  input  logic                clk_i,
  input  logic                en_i,
  input  tpo_pkg::vec_set_t   edge_i [9],
  input  tpo_pkg::vec_set_t   cont_i [2],
  output tpo_pkg::cross_set_t edge_o [9],
  output tpo_pkg::cross_set_t cont_o [2]
);

  tpo_pkg::cross_set_t edge_d [9];
  tpo_pkg::cross_set_t cont_d [2];
  tpo_pkg::cross_set_t edge_q [9];
  tpo_pkg::cross_set_t cont_q [2];

  // Edge pairs: d = r x s, n0 = w x s, n1 = w x r.
  for (genvar k = 0; k < 9; k++) begin : g_e
    always_comb begin
      edge_d[k].d  = tpo_pkg::cross_v(edge_i[k].rx, edge_i[k].ry,
                                      edge_i[k].sx, edge_i[k].sy);
      edge_d[k].n0 = tpo_pkg::cross_v(edge_i[k].wx, edge_i[k].wy,
                                      edge_i[k].sx, edge_i[k].sy);
      edge_d[k].n1 = tpo_pkg::cross_v(edge_i[k].wx, edge_i[k].wy,
                                      edge_i[k].rx, edge_i[k].ry);
    end
  end

  // Containment: D = v0 x v1, nu = v2 x v1, nv = v0 x v2.
  for (genvar k = 0; k < 2; k++) begin : g_c
    always_comb begin
      cont_d[k].d  = tpo_pkg::cross_v(cont_i[k].rx, cont_i[k].ry,
                                      cont_i[k].sx, cont_i[k].sy);
      cont_d[k].n0 = tpo_pkg::cross_v(cont_i[k].wx, cont_i[k].wy,
                                      cont_i[k].sx, cont_i[k].sy);
      cont_d[k].n1 = tpo_pkg::cross_v(cont_i[k].rx, cont_i[k].ry,
                                      cont_i[k].wx, cont_i[k].wy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      edge_q <= edge_d;
      cont_q <= cont_d;
    end
  end

  assign edge_o = edge_q;
  assign cont_o = cont_q;

endmodule

// ===== design/tpo_decide.sv =====
// Stage 3: sign-aware ratio compares and the final reduction.
module tpo_decide (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  tpo_pkg::cross_set_t  edge_i [9],
  input  tpo_pkg::cross_set_t  cont_i [2],
  output tpo_pkg::tpo_result_t res_o
);

  logic [8:0] hit;
  logic [1:0] ins;
  tpo_pkg::tpo_result_t res_d;
  tpo_pkg::tpo_result_t res_q;

  // A parallel pair never hits.
  for (genvar k = 0; k < 9; k++) begin : g_e
    assign hit[k] = (edge_i[k].d != '0) &&
                    tpo_pkg::unit_ratio(edge_i[k].n0, edge_i[k].d) &&
                    tpo_pkg::unit_ratio(edge_i[k].n1, edge_i[k].d);
  end

  // A degenerate triangle contains nothing.
  for (genvar k = 0; k < 2; k++) begin : g_c
    tpo_pkg::cross_t sum;
    assign sum = cont_i[k].n0 + cont_i[k].n1;
    always_comb begin
      if (cont_i[k].d > 0) begin
        ins[k] = (cont_i[k].n0 >= 0) && (cont_i[k].n1 >= 0) && (sum <= cont_i[k].d);
      end else if (cont_i[k].d < 0) begin
        ins[k] = (cont_i[k].n0 <= 0) && (cont_i[k].n1 <= 0) && (sum >= cont_i[k].d);
      end else begin
        ins[k] = 1'b0;
      end
    end
  end

  always_comb begin
    res_d.edge_crossing = |hit;
    res_d.vertex_inside = |ins;
    res_d.overlap       = (|hit) | (|ins);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/triangle_pair_overlap_test_top.sv =====
// Pipeline: three register stages (vectors, cross products, compares); a result passes
// through them in that order and is held at the output until it transfers.
// Throughput: one triangle pair per cycle unless the output stalls; the three-stage pipeline
// advances whenever its last stage is empty or the output transfer happens.
// Reset: asynchronous active-low reset clears all stage valid bits; the data path is not reset.
module triangle_pair_overlap_test_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tpo_pkg::tri_pair_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tpo_pkg::tpo_result_t out_data_o
);

  logic [2:0] vld_q;
  logic [2:0] vld_d;
  logic       adv;

  tpo_pkg::vec_set_t   vec_edge [9];
  tpo_pkg::vec_set_t   vec_cont [2];
  tpo_pkg::cross_set_t crs_edge [9];
  tpo_pkg::cross_set_t crs_cont [2];

  // The whole pipeline moves together whenever the output stage can drain.
  assign adv        = !vld_q[2] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    vld_d = vld_q;
    if (adv) begin
      vld_d = {vld_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  tpo_vec u_vec (
    .clk_i  (clk_i),
    .en_i   (adv),
    .in_i   (in_data_i),
    .edge_o (vec_edge),
    .cont_o (vec_cont)
  );

  tpo_cross u_cross (
    .clk_i  (clk_i),
    .en_i   (adv),
    .edge_i (vec_edge),
    .cont_i (vec_cont),
    .edge_o (crs_edge),
    .cont_o (crs_cont)
  );

  tpo_decide u_decide (
    .clk_i  (clk_i),
    .en_i   (adv),
    .edge_i (crs_edge),
    .cont_i (crs_cont),
    .res_o  (out_data_o)
  );

  assign out_valid_o = vld_q[2];

endmodule

// ===== design/tpo_checker.sv =====
// Port-level checks on the overlap test.
module tpo_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input tpo_pkg::tpo_result_t out_data_o
);

  // Overlap is exactly the OR of the two tests.
  a_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.overlap ==
                     (out_data_o.edge_crossing | out_data_o.vertex_inside)))
    else $error("overlap flag mismatch");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input is never refused while the output side drains.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled with output ready");

  // An accepted item shows up at the output if nothing stalls.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o)
    else $error("result missing after three cycles");

endmodule

bind triangle_pair_overlap_test_top tpo_checker u_tpo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== test/tb_triangle_pair_overlap_test_top.sv =====
module tb_triangle_pair_overlap_test_top;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  tpo_pkg::tri_pair_t   in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  tpo_pkg::tpo_result_t out_data_o;

  tpo_pkg::tri_pair_t   pair_q[$];
  tpo_pkg::tpo_result_t overlap_exp_q[$];
  int          fail_cnt;
  bit          stim_done;
  bit          calm;
  int          in_gap;
  int          out_gap;
  logic        in_ready_o_q;

  triangle_pair_overlap_test_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Cross product of two vectors held as 64-bit integers.
  function automatic longint xprod(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  // Exact test of 0 <= n/d <= 1 for nonzero d.
  function automatic bit in_unit(longint n, longint d);
    if (d > 0) begin
      return n >= 0 && n <= d;
    end
    return n <= 0 && n >= d;
  endfunction

  // Segment p1-p2 against q1-q2; parallel pairs never hit.
  function automatic bit seg_cross(longint p1x, longint p1y, longint p2x, longint p2y,
                                   longint q1x, longint q1y, longint q2x, longint q2y);
    longint d;
    d = xprod(p2x - p1x, p2y - p1y, q2x - q1x, q2y - q1y);
    if (d == 0) begin
      return 1'b0;
    end
    return in_unit(xprod(q1x - p1x, q1y - p1y, q2x - q1x, q2y - q1y), d) &&
           in_unit(xprod(q1x - p1x, q1y - p1y, p2x - p1x, p2y - p1y), d);
  endfunction

  // Barycentric containment of point p in triangle (a,b,c), boundary included.
  function automatic bit pt_in_tri(longint px, longint py, longint ax, longint ay,
                                   longint bx, longint by, longint cx, longint cy);
    longint d;
    longint nu;
    longint nv;
    d  = xprod(cx - ax, cy - ay, bx - ax, by - ay);
    nu = xprod(px - ax, py - ay, bx - ax, by - ay);
    nv = xprod(cx - ax, cy - ay, px - ax, py - ay);
    if (d > 0) begin
      return nu >= 0 && nv >= 0 && nu + nv <= d;
    end
    if (d < 0) begin
      return nu <= 0 && nv <= 0 && nu + nv >= d;
    end
    return 1'b0;
  endfunction

  // Predict the overlap flags for one triangle pair.
  function automatic tpo_pkg::tpo_result_t overlap_predict(tpo_pkg::tri_pair_t p);
    longint ax[3];
    longint ay[3];
    longint bx[3];
    longint by[3];
    tpo_pkg::tpo_result_t r;
    bit edge_hit;
    bit vin;
    ax[0] = p.a_x0; ay[0] = p.a_y0; ax[1] = p.a_x1;
    ay[1] = p.a_y1; ax[2] = p.a_x2; ay[2] = p.a_y2;
    bx[0] = p.b_x0; by[0] = p.b_y0; bx[1] = p.b_x1;
    by[1] = p.b_y1; bx[2] = p.b_x2; by[2] = p.b_y2;
    edge_hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (seg_cross(ax[i], ay[i], ax[(i+1)%3], ay[(i+1)%3],
                      bx[j], by[j], bx[(j+1)%3], by[(j+1)%3])) begin
          edge_hit = 1'b1;
        end
      end
    end
    vin = pt_in_tri(ax[0], ay[0], bx[0], by[0], bx[1], by[1], bx[2], by[2]) ||
          pt_in_tri(bx[0], by[0], ax[0], ay[0], ax[1], ay[1], ax[2], ay[2]);
    r.overlap       = edge_hit | vin;
    r.edge_crossing = edge_hit;
    r.vertex_inside = vin;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    fail_cnt++;
  endtask

  function automatic tpo_pkg::coord_t rnd_coord(int span);
    return tpo_pkg::coord_t'($urandom_range(2 * span) - span);
  endfunction

  // Random pair around the origin; the mode picks the spread, or fully random bits.
  function automatic tpo_pkg::tri_pair_t rnd_pair();
    tpo_pkg::tri_pair_t p;
    logic [159:0]       raw;
    int span;
    int mode;
    mode = $urandom_range(9);
    if (mode == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      p   = tpo_pkg::tri_pair_t'(raw[143:0]);
    end else begin
      span = (mode < 4) ? 8 : (mode < 8) ? 300 : 2047;
      p.a_x0 = rnd_coord(span); p.a_y0 = rnd_coord(span);
      p.a_x1 = rnd_coord(span); p.a_y1 = rnd_coord(span);
      p.a_x2 = rnd_coord(span); p.a_y2 = rnd_coord(span);
      p.b_x0 = rnd_coord(span); p.b_y0 = rnd_coord(span);
      p.b_x1 = rnd_coord(span); p.b_y1 = rnd_coord(span);
      p.b_x2 = rnd_coord(span); p.b_y2 = rnd_coord(span);
      // Sometimes share a vertex or make one triangle degenerate.
      if ($urandom_range(5) == 0) begin
        p.b_x1 = p.a_x2; p.b_y1 = p.a_y2;
      end
      if ($urandom_range(7) == 0) begin
        p.a_x2 = p.a_x1; p.a_y2 = p.a_y1;
      end
    end
    return p;
  endfunction

  function automatic tpo_pkg::tri_pair_t mk(int v[12]);
    tpo_pkg::tri_pair_t p;
    p.a_x0 = tpo_pkg::coord_t'(v[0]);  p.a_y0 = tpo_pkg::coord_t'(v[1]);
    p.a_x1 = tpo_pkg::coord_t'(v[2]);  p.a_y1 = tpo_pkg::coord_t'(v[3]);
    p.a_x2 = tpo_pkg::coord_t'(v[4]);  p.a_y2 = tpo_pkg::coord_t'(v[5]);
    p.b_x0 = tpo_pkg::coord_t'(v[6]);  p.b_y0 = tpo_pkg::coord_t'(v[7]);
    p.b_x1 = tpo_pkg::coord_t'(v[8]);  p.b_y1 = tpo_pkg::coord_t'(v[9]);
    p.b_x2 = tpo_pkg::coord_t'(v[10]); p.b_y2 = tpo_pkg::coord_t'(v[11]);
    return p;
  endfunction

  // Stimulus: directed corner cases, then random pairs.
  initial begin
    tpo_pkg::tri_pair_t p;
    fail_cnt  = 0;
    stim_done = 1'b0;
    calm      = 1'b0;
    rst_ni    = 1'b0;
    // Disjoint triangles.
    pair_q.push_back(mk('{0, 0, 10, 0, 0, 10, 100, 100, 110, 100, 100, 110}));
    // Crossing edges.
    pair_q.push_back(mk('{0, 0, 20, 0, 0, 20, 5, -5, 5, 30, 30, 5}));
    // B wholly inside A.
    pair_q.push_back(mk('{-100, -100, 100, -100, 0, 100, 0, 0, 5, 0, 0, 5}));
    // A wholly inside B.
    pair_q.push_back(mk('{0, 0, 5, 0, 0, 5, -100, -100, 100, -100, 0, 100}));
    // Collinear overlapping edges only.
    pair_q.push_back(mk('{0, 0, 10, 0, 5, -10, 5, 0, 20, 0, 12, 10}));
    // Shared vertex touch.
    pair_q.push_back(mk('{0, 0, 10, 0, 0, 10, 10, 0, 20, 0, 20, 10}));
    // Degenerate triangles.
    pair_q.push_back(mk('{0, 0, 0, 0, 0, 0, -5, -5, 5, -5, 0, 5}));
    pair_q.push_back(mk('{0, 0, 4, 4, 8, 8, -5, -5, 5, -5, 0, 5}));
    // Vertex on the boundary of the other triangle.
    pair_q.push_back(mk('{5, 0, 30, 30, 40, 30, 0, 0, 10, 0, 0, 10}));
    // Coordinate extremes.
    pair_q.push_back(mk('{-2048, -2048, 2047, -2048, -2048, 2047,
                          2047, 2047, -2048, 2047, 2047, -2048}));
    pair_q.push_back(mk('{-2048, -2048, -2048, -2048, 2047, 2047,
                          -2048, 2047, 2047, -2048, 0, 0}));
    pair_q.push_back(mk('{2047, 2047, -2048, -2048, 2047, -2048,
                          -2048, -2048, 2047, 2047, -2048, 2047}));
    pair_q.push_back(mk('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}));
    // Orientation swapped.
    pair_q.push_back(mk('{0, 0, 0, 20, 20, 0, 5, 5, 6, 5, 5, 6}));
    for (int k = 0; k < 940; k++) begin
      p = rnd_pair();
      pair_q.push_back(p);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pair_q.size() < 100);
    calm = 1'b1;
    wait (pair_q.size() == 0 && !in_valid_i);
    stim_done = 1'b1;
  end

  // Driver: presents queued pairs with random bursts of idle cycles.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
    end else if (!in_valid_i || in_ready_o_q) begin
      if (in_gap > 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pair_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pair_q.pop_front();
        if (!calm && $urandom_range(7) == 0) begin
          in_gap <= $urandom_range(13, 1);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Acceptance is seen at the rising edge and registered for the driver, which acts on the falling edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ready_o_q <= 1'b0;
    end else begin
      in_ready_o_q <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        overlap_exp_q.push_back(overlap_predict(in_data_i));
      end
    end
  end

  // Receiver backpressure in random bursts.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else if (out_gap > 0) begin
      out_gap     <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(7) == 0) begin
      out_gap     <= $urandom_range(13, 1) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    tpo_pkg::tpo_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (overlap_exp_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        exp_r = overlap_exp_q.pop_front();
        if (out_data_o.overlap !== exp_r.overlap) begin
          report_mismatch($sformatf("overlap got %b want %b",
                                    out_data_o.overlap, exp_r.overlap));
        end
        if (out_data_o.edge_crossing !== exp_r.edge_crossing) begin
          report_mismatch($sformatf("edge_crossing got %b want %b",
                                    out_data_o.edge_crossing, exp_r.edge_crossing));
        end
        if (out_data_o.vertex_inside !== exp_r.vertex_inside) begin
          report_mismatch($sformatf("vertex_inside got %b want %b",
                                    out_data_o.vertex_inside, exp_r.vertex_inside));
        end
      end
    end
  end

  // End of run: drain the pipeline, then report the verdict.
  initial begin
    wait (stim_done);
    wait (overlap_exp_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && overlap_exp_q.size() == 0) begin
      $display("tb_triangle_pair_overlap_test_top OK");
    end else begin
      $display("tb_triangle_pair_overlap_test_top NOT OK");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("tb_triangle_pair_overlap_test_top NOT OK");
    $finish;
  end

endmodule
